FILE: hdl/tss_pkg.sv
// Shared types and constants of the timed subtask sequencer.
package tss_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBTASK_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ZERO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ONE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TWO    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_THREE  = 3'd5;

	localparam int TIME_W  = 32;
	localparam int ROUND_W = 16;
	localparam int SLOT_W  = 3;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] now;
	} tss_cmd_t;

	typedef struct packed {
		logic               fired;
		logic [1:0]         fired_index;
		logic               running;
		logic [ROUND_W-1:0] rounds_done;
		logic               finished;
	} tss_rsp_t;

	typedef struct packed {
		logic [ROUND_W-1:0] round_limit;
		logic [SLOT_W-1:0]  subtask_count;
	} tss_ctrl_t;

endpackage

FILE: hdl/tss_cfg_regs.sv
// Configuration register file: round limit, subtask count and subtask periods.
module tss_cfg_regs import tss_pkg::*; #(
	parameter int MAX_SUBTASKS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0]     cfg_data,
	output tss_ctrl_t             ctrl,
	output logic [TIME_W-1:0]     periods [MAX_SUBTASKS]
);

	tss_ctrl_t         ctrl_q;
	logic [TIME_W-1:0] period_q [MAX_SUBTASKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			for (int i = 0; i < MAX_SUBTASKS; i++) begin
				period_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROUND_LIMIT:   ctrl_q.round_limit <= cfg_data[ROUND_W-1:0];
				CFG_SUBTASK_COUNT: ctrl_q.subtask_count <= cfg_data[SLOT_W-1:0];
				CFG_PERIOD_ZERO:   period_q[0] <= cfg_data;
				CFG_PERIOD_ONE:    if (MAX_SUBTASKS > 1) period_q[1 % MAX_SUBTASKS] <= cfg_data;
				CFG_PERIOD_TWO:    if (MAX_SUBTASKS > 2) period_q[2 % MAX_SUBTASKS] <= cfg_data;
				CFG_PERIOD_THREE:  if (MAX_SUBTASKS > 3) period_q[3 % MAX_SUBTASKS] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ctrl    = ctrl_q;
	assign periods = period_q;

endmodule

FILE: hdl/tss_core.sv
// Sequencer state and the per-command update that forms one response word.
module tss_core import tss_pkg::*; #(
	parameter int MAX_SUBTASKS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tss_cmd_t          cmd_s1,
	input  tss_ctrl_t         ctrl,
	input  logic [TIME_W-1:0] periods [MAX_SUBTASKS],
	output tss_rsp_t          rsp_next
);

	localparam int IDX_W = (MAX_SUBTASKS > 1) ? $clog2(MAX_SUBTASKS) : 1;
	localparam logic [SLOT_W-1:0] MAX_CNT = SLOT_W'(MAX_SUBTASKS);

	logic               active_q, armed_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ROUND_W-1:0] round_q;
	logic [TIME_W-1:0]  mark_q;

	logic               active_d, armed_d;
	logic [SLOT_W-1:0]  slot_d;
	logic [ROUND_W-1:0] round_d;
	logic [TIME_W-1:0]  mark_d;

	logic [SLOT_W-1:0]  count;
	logic [TIME_W-1:0]  period_sel, trigger;
	logic               wait_over, limit_hit, fired;
	logic [1:0]         fired_index;

	assign count      = (ctrl.subtask_count > MAX_CNT) ? MAX_CNT : ctrl.subtask_count;
	assign period_sel = periods[slot_q[IDX_W-1:0]];
	assign trigger    = mark_q + period_sel;
	assign wait_over  = ((trigger > mark_q) && (cmd_s1.now >= trigger)) ||
	                    ((cmd_s1.now < mark_q) && (cmd_s1.now >= trigger));

	always_comb begin
		active_d    = active_q;
		armed_d     = armed_q;
		slot_d      = slot_q;
		round_d     = round_q;
		mark_d      = mark_q;
		fired       = 1'b0;
		fired_index = 2'd0;
		priority if (cmd_s1.op == OP_START) begin
			active_d = 1'b1;
			armed_d  = 1'b1;
			round_d  = '0;
			slot_d   = '0;
			mark_d   = cmd_s1.now;
		end else if (cmd_s1.op == OP_STOP) begin
			active_d = 1'b0;
		end else if (cmd_s1.op == OP_TICK && active_q) begin
			if (slot_q < count) begin
				if (armed_q) begin
					fired       = 1'b1;
					fired_index = slot_q[1:0];
					mark_d      = cmd_s1.now;
					armed_d     = 1'b0;
				end else if (wait_over) begin
					armed_d = 1'b1;
					slot_d  = slot_q + SLOT_W'(1);
				end
			end else begin
				round_d = round_q + ROUND_W'(1);
				slot_d  = '0;
				mark_d  = cmd_s1.now;
				if (ctrl.round_limit != '0 && round_d >= ctrl.round_limit) begin
					active_d = 1'b0;
				end
			end
		end else begin
			// hold on a spare command or a tick while stopped
		end
	end

	assign limit_hit = (ctrl.round_limit != '0) && (round_d >= ctrl.round_limit);

	always_comb begin
		rsp_next.fired       = fired;
		rsp_next.fired_index = fired_index;
		rsp_next.running     = active_d;
		rsp_next.rounds_done = round_d;
		rsp_next.finished    = limit_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			armed_q  <= 1'b0;
			slot_q   <= '0;
			round_q  <= '0;
			mark_q   <= '0;
		end else if (advance) begin
			active_q <= active_d;
			armed_q  <= armed_d;
			slot_q   <= slot_d;
			round_q  <= round_d;
			mark_q   <= mark_d;
		end
	end

endmodule

FILE: hdl/tss_out_buf.sv
// Two-word response buffer that decouples the response stall from the command side.
module tss_out_buf import tss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tss_rsp_t push_word,
	output logic     full,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output tss_rsp_t rsp
);

	tss_rsp_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp       = mem_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: hdl/timed_subtask_sequencer_unit.sv
// Top level of the timed subtask sequencer: command register, state update, response buffer.
// One command word (tick, start or stop with the current time) is taken per clock while
// cmd_stall is low, and yields exactly one response word. A command is registered on
// acceptance, the sequencer state is updated as the word moves from that register into a
// two-word response buffer, which waits while the buffer is full, and the response is
// offered from that buffer, so throughput is one word per clock as long as the response
// side keeps up; cmd_stall rises only when the buffer is full. Configuration writes are
// always ready and should be issued while no command is in flight. Periods are compared
// against the current time with wrap-aware logic; a zero period never elapses.
module timed_subtask_sequencer_unit import tss_pkg::*; #(
	parameter int MAX_SUBTASKS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  tss_cmd_t             cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tss_rsp_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	tss_cmd_t          cmd_s1;
	logic              valid_s1;
	logic              accept, advance, full;
	tss_ctrl_t         ctrl;
	logic [TIME_W-1:0] periods [MAX_SUBTASKS];
	tss_rsp_t          rsp_next;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !full;
	assign cmd_stall = valid_s1 && full;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	tss_cfg_regs #(.MAX_SUBTASKS(MAX_SUBTASKS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.periods   (periods)
	);

	tss_core #(.MAX_SUBTASKS(MAX_SUBTASKS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cmd_s1   (cmd_s1),
		.ctrl     (ctrl),
		.periods  (periods),
		.rsp_next (rsp_next)
	);

	tss_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_word (rsp_next),
		.full      (full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: hdl/tss_checker.sv
// Port-level checks on the response channel of the timed subtask sequencer.
module tss_checker import tss_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input tss_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.fired |-> rsp.fired_index == 2'd0)
		else $error("fired_index set without a fire");

	a_fire_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fired |-> rsp.running)
		else $error("subtask fired while not running");

	a_fin_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.finished |-> rsp.rounds_done != '0)
		else $error("finished with no completed round");

endmodule

bind timed_subtask_sequencer_unit tss_checker u_tss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: bench/timed_subtask_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the timed subtask sequencer: directed corner cases, then random rounds.
module timed_subtask_sequencer_unit_test;
	import tss_pkg::*;

	localparam int MAX_SUBTASKS = 4;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_SIX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_SEVEN = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	tss_cmd_t             cmd = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	tss_rsp_t             rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data = '0;

	// predicted sequencer state and register copies
	logic                 seq_run = 1'b0;
	logic                 seq_armed = 1'b0;
	logic [SLOT_W-1:0]    seq_slot = '0;
	logic [ROUND_W-1:0]   seq_rounds = '0;
	logic [TIME_W-1:0]    seq_mark = '0;
	logic [ROUND_W-1:0]   limit_cfg = '0;
	logic [SLOT_W-1:0]    count_cfg = '0;
	logic [TIME_W-1:0]    period_cfg [4] = '{default: '0};

	tss_rsp_t             pending_rsp_q [$];
	tss_rsp_t             exp_rsp;
	int                   mismatch_cnt = 0;
	int                   stall_left = 0;
	bit                   sender_gaps_on = 1'b1;
	bit                   stall_gaps_on = 1'b1;

	timed_subtask_sequencer_unit #(
		.MAX_SUBTASKS(MAX_SUBTASKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic limit_hit();
		return limit_cfg != '0 && seq_rounds >= limit_cfg;
	endfunction

	function automatic logic wait_done(logic [TIME_W-1:0] period, logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] trig;
		trig = seq_mark + period;
		return (trig > seq_mark && t >= trig) || (t < seq_mark && t >= trig);
	endfunction

	function automatic tss_rsp_t advance_sequencer(tss_cmd_t c);
		tss_rsp_t r;
		logic [SLOT_W-1:0] eff_count;
		r = '0;
		eff_count = (count_cfg > SLOT_W'(MAX_SUBTASKS)) ? SLOT_W'(MAX_SUBTASKS) : count_cfg;
		case (c.op)
			OP_START: begin
				seq_run = 1'b1;
				seq_armed = 1'b1;
				seq_rounds = '0;
				seq_slot = '0;
				seq_mark = c.now;
			end
			OP_STOP: begin
				seq_run = 1'b0;
			end
			OP_TICK: begin
				if (seq_run) begin
					if (seq_slot < eff_count) begin
						if (seq_armed) begin
							r.fired = 1'b1;
							r.fired_index = seq_slot[1:0];
							seq_mark = c.now;
							seq_armed = 1'b0;
						end else if (wait_done(period_cfg[seq_slot[1:0]], c.now)) begin
							seq_armed = 1'b1;
							seq_slot = seq_slot + SLOT_W'(1);
						end
					end else begin
						seq_rounds = seq_rounds + ROUND_W'(1);
						seq_slot = '0;
						seq_mark = c.now;
						if (limit_hit())
							seq_run = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		r.running = seq_run;
		r.rounds_done = seq_rounds;
		r.finished = limit_hit();
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				note_mismatch("unexpected word", '0, 32'(rsp));
			end else begin
				exp_rsp = pending_rsp_q.pop_front();
				if (rsp.fired !== exp_rsp.fired)
					note_mismatch("fired", 32'(exp_rsp.fired), 32'(rsp.fired));
				if (rsp.fired_index !== exp_rsp.fired_index)
					note_mismatch("fired_index", 32'(exp_rsp.fired_index),
						32'(rsp.fired_index));
				if (rsp.running !== exp_rsp.running)
					note_mismatch("running", 32'(exp_rsp.running), 32'(rsp.running));
				if (rsp.rounds_done !== exp_rsp.rounds_done)
					note_mismatch("rounds_done", 32'(exp_rsp.rounds_done),
						32'(rsp.rounds_done));
				if (rsp.finished !== exp_rsp.finished)
					note_mismatch("finished", 32'(exp_rsp.finished), 32'(rsp.finished));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_gaps_on && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 15);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_cmd(input logic [1:0] op, input logic [TIME_W-1:0] t);
		tss_cmd_t c;
		int gap;
		c.op = op;
		c.now = t;
		if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		pending_rsp_q.push_back(advance_sequencer(c));
	endtask

	// hold commands until every response word is back
	task automatic settle_bus();
		cmd_valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ROUND_LIMIT:   limit_cfg = val[ROUND_W-1:0];
			CFG_SUBTASK_COUNT: count_cfg = val[SLOT_W-1:0];
			CFG_PERIOD_ZERO:   period_cfg[0] = val;
			CFG_PERIOD_ONE:    period_cfg[1] = val;
			CFG_PERIOD_TWO:    period_cfg[2] = val;
			CFG_PERIOD_THREE:  period_cfg[3] = val;
			default: begin
			end
		endcase
	endtask

	task automatic program_regs(input logic [TIME_W-1:0] lim, input logic [TIME_W-1:0] cnt,
			input logic [TIME_W-1:0] p0, input logic [TIME_W-1:0] p1,
			input logic [TIME_W-1:0] p2, input logic [TIME_W-1:0] p3);
		settle_bus();
		write_reg(CFG_ROUND_LIMIT, lim);
		write_reg(CFG_SUBTASK_COUNT, cnt);
		write_reg(CFG_PERIOD_ZERO, p0);
		write_reg(CFG_PERIOD_ONE, p1);
		write_reg(CFG_PERIOD_TWO, p2);
		write_reg(CFG_PERIOD_THREE, p3);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_idle_commands();
		settle_bus();
		write_reg(CFG_SPARE_SIX, $urandom);
		write_reg(CFG_SPARE_SEVEN, $urandom);
		cfg_valid <= 1'b0;
		send_cmd(OP_TICK, 32'h0);
		send_cmd(OP_SPARE, 32'hFFFF_FFFF);
		send_cmd(OP_STOP, 32'h0);
		send_cmd(OP_TICK, 32'hFFFF_FFFF);
	endtask

	task automatic test_zero_count();
		program_regs(32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_cmd(OP_START, 32'd100);
		send_cmd(OP_TICK, 32'd100);
		send_cmd(OP_TICK, 32'd101);
		send_cmd(OP_TICK, 32'd102);
	endtask

	task automatic test_zero_period();
		program_regs(32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_cmd(OP_START, 32'd5);
		send_cmd(OP_TICK, 32'd5);
		send_cmd(OP_TICK, 32'hFFFF_FFFF);
	endtask

	task automatic test_time_wrap();
		program_regs(32'd1, 32'd2, 32'h20, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_cmd(OP_START, 32'hFFFF_FFF0);
		send_cmd(OP_TICK, 32'hFFFF_FFF0);
		send_cmd(OP_TICK, 32'hFFFF_FFFF);
		send_cmd(OP_TICK, 32'h0F);
		send_cmd(OP_TICK, 32'h10);
		send_cmd(OP_TICK, 32'h11);
		send_cmd(OP_TICK, 32'h12);
		send_cmd(OP_TICK, 32'h10);
		send_cmd(OP_TICK, 32'h10);
	endtask

	task automatic test_count_clamp();
		logic [TIME_W-1:0] t;
		program_regs(32'd0, 32'd7, 32'd1, 32'd1, 32'd1, 32'd1);
		t = '0;
		send_cmd(OP_START, t);
		repeat (MAX_SUBTASKS) begin
			send_cmd(OP_TICK, t);
			t = t + TIME_W'(1);
			send_cmd(OP_TICK, t);
		end
		send_cmd(OP_TICK, t);
	endtask

	task automatic test_random_rounds();
		logic [TIME_W-1:0] lim;
		logic [TIME_W-1:0] cnt;
		logic [TIME_W-1:0] per [4];
		logic [TIME_W-1:0] now_t;
		int unsigned pick;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: lim = 32'd0;
				1: lim = 32'hFFFF_FFFF;
				2: lim = {16'($urandom_range(0, 65535)), 16'd1};
				default: lim = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 6))};
			endcase
			cnt = {29'($urandom), 3'd0};
			case (ph)
				0: cnt[2:0] = 3'd4;
				1: cnt[2:0] = 3'd7;
				2: cnt[2:0] = 3'd0;
				default: cnt[2:0] = 3'($urandom_range(0, 7));
			endcase
			for (int k = 0; k < 4; k++) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0: per[k] = 32'd0;
					1: per[k] = 32'hFFFF_FFFF;
					2: per[k] = $urandom;
					default: per[k] = $urandom_range(1, 6);
				endcase
			end
			program_regs(lim, cnt, per[0], per[1], per[2], per[3]);
			sender_gaps_on = (ph != PHASES - 1);
			stall_gaps_on = (ph != PHASES - 1);
			if ($urandom_range(0, 2) == 0)
				now_t = 32'hFFFF_FFC0 + $urandom_range(0, 63);
			else
				now_t = $urandom;
			send_cmd(OP_START, now_t);
			for (int n = 1; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 63);
				if (!seq_run && $urandom_range(0, 3) == 0)
					send_cmd(OP_START, now_t);
				else if (pick == 0)
					send_cmd(2'($urandom_range(0, 3)), $urandom);
				else if (pick == 1)
					send_cmd(OP_STOP, now_t);
				else if (pick == 2)
					send_cmd(OP_START, now_t);
				else if (pick == 3)
					send_cmd(OP_SPARE, $urandom);
				else begin
					if (pick == 4)
						now_t = now_t + $urandom;
					else
						now_t = now_t + $urandom_range(0, 4);
					send_cmd(OP_TICK, now_t);
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_commands();
		test_zero_count();
		test_zero_period();
		test_time_wrap();
		test_count_clamp();
		test_random_rounds();
		settle_bus();
		repeat (6) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
